>>> rtl/tbw_pkg.sv
// Shared types, constants and helper functions for the barycentric weight block.
`default_nettype none
package tbw_pkg;

  localparam int SCREEN_MAX       = 512;
  localparam int VERT_FRAC_BITS   = 4;
  localparam int WEIGHT_FRAC_BITS = 14;

  localparam int VERT_W   = 16;
  localparam int PIX_W    = 10;
  localparam int WEIGHT_W = 18;
  localparam int BOX_W    = 10;
  localparam int CFG_IDX_W = 3;

  // Datapath widths, all derived from the field widths above.
  localparam int DIFF_W = VERT_W + 1;
  localparam int PXF_W  = PIX_W + VERT_FRAC_BITS + 1;
  localparam int MULP_W = DIFF_W + PXF_W;
  localparam int MULD_W = DIFF_W + VERT_W;
  localparam int MULK_W = 2 * VERT_W;
  localparam int SUM_W  = ((MULP_W > MULD_W) ? MULP_W : MULD_W) + 2;
  localparam int DEN_W  = SUM_W + 1;
  localparam int NUM_W  = SUM_W + WEIGHT_FRAC_BITS + 2;
  localparam int Q_W    = NUM_W;
  localparam int ALPHA_W = Q_W + 3;
  localparam int FRAC_M1 = (1 << VERT_FRAC_BITS) - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AX = 3'd0,
    REG_AY = 3'd1,
    REG_BX = 3'd2,
    REG_BY = 3'd3,
    REG_CX = 3'd4,
    REG_CY = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VERT_W-1:0] ax;
    logic signed [VERT_W-1:0] ay;
    logic signed [VERT_W-1:0] bx;
    logic signed [VERT_W-1:0] by;
    logic signed [VERT_W-1:0] cx;
    logic signed [VERT_W-1:0] cy;
  } vtx_t;

  typedef struct packed {
    logic [BOX_W-1:0] min_x;
    logic [BOX_W-1:0] max_x;
    logic [BOX_W-1:0] min_y;
    logic [BOX_W-1:0] max_y;
  } box_t;

  // Per-item flags that ride along with the weight datapath.
  typedef struct packed {
    logic deg;
    logic neg_b;
    logic neg_g;
    logic in_box;
  } side_t;

  function automatic logic signed [VERT_W:0] fx_floor(input logic signed [VERT_W-1:0] v);
    logic signed [VERT_W:0] e;
    e = {v[VERT_W-1], v};
    return e >>> VERT_FRAC_BITS;
  endfunction

  function automatic logic signed [VERT_W:0] fx_ceil(input logic signed [VERT_W-1:0] v);
    logic signed [VERT_W:0] e;
    e = {v[VERT_W-1], v} + (VERT_W+1)'(FRAC_M1);
    return e >>> VERT_FRAC_BITS;
  endfunction

  function automatic logic [BOX_W-1:0] clamp_box(input logic signed [VERT_W:0] v);
    logic [BOX_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > SCREEN_MAX) begin
      r = BOX_W'(SCREEN_MAX);
    end else begin
      r = v[BOX_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] sat_w(input logic signed [ALPHA_W-1:0] v);
    logic signed [WEIGHT_W-1:0] r;
    if (v < -(ALPHA_W'(1) <<< (WEIGHT_W-1))) begin
      r = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else if (v > ((ALPHA_W'(1) <<< (WEIGHT_W-1)) - ALPHA_W'(1))) begin
      r = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else begin
      r = v[WEIGHT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tbw_box.sv
// Bounding box of the configured triangle, floored/ceiled and clamped to screen.
`default_nettype none
module tbw_box (
  input  wire logic          clk,
  input  wire tbw_pkg::vtx_t vtx,
  output tbw_pkg::box_t      box_r
);

  logic signed [tbw_pkg::VERT_W-1:0] min_x, max_x, min_y, max_y;
  tbw_pkg::box_t box_nxt;

  always_comb begin
    min_x = (vtx.ax < vtx.bx) ? vtx.ax : vtx.bx;
    min_x = (min_x < vtx.cx) ? min_x : vtx.cx;
    max_x = (vtx.ax > vtx.bx) ? vtx.ax : vtx.bx;
    max_x = (max_x > vtx.cx) ? max_x : vtx.cx;
    min_y = (vtx.ay < vtx.by) ? vtx.ay : vtx.by;
    min_y = (min_y < vtx.cy) ? min_y : vtx.cy;
    max_y = (vtx.ay > vtx.by) ? vtx.ay : vtx.by;
    max_y = (max_y > vtx.cy) ? max_y : vtx.cy;
    box_nxt.min_x = tbw_pkg::clamp_box(tbw_pkg::fx_floor(min_x));
    box_nxt.max_x = tbw_pkg::clamp_box(tbw_pkg::fx_ceil(max_x));
    box_nxt.min_y = tbw_pkg::clamp_box(tbw_pkg::fx_floor(min_y));
    box_nxt.max_y = tbw_pkg::clamp_box(tbw_pkg::fx_ceil(max_y));
  end

  always_ff @(posedge clk) begin
    box_r <= box_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/tbw_plane.sv
// Plane-equation numerators and determinants, turned into unsigned divide operands.
`default_nettype none
module tbw_plane (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [tbw_pkg::PIX_W-1:0]   in_px,
  input  wire logic [tbw_pkg::PIX_W-1:0]   in_py,
  input  wire tbw_pkg::vtx_t               vtx,
  input  wire tbw_pkg::box_t               box,
  output logic                             out_valid,
  output logic [tbw_pkg::NUM_W-1:0]        num_b,
  output logic [tbw_pkg::DEN_W-1:0]        den_b,
  output logic [tbw_pkg::NUM_W-1:0]        num_g,
  output logic [tbw_pkg::DEN_W-1:0]        den_g,
  output tbw_pkg::side_t                   side
);

  localparam int SW = tbw_pkg::SUM_W;
  localparam int WF = tbw_pkg::WEIGHT_FRAC_BITS;

  logic [4:0] vld_r;

  // Stage 1: pixel and edge differences
  logic [tbw_pkg::PIX_W-1:0] px_r, py_r;
  logic signed [tbw_pkg::DIFF_W-1:0] db1_r, db2_r, dg1_r, dg2_r;

  // Stage 2: products
  logic signed [tbw_pkg::MULP_W-1:0] pb1_r, pb2_r, pg1_r, pg2_r;
  logic signed [tbw_pkg::MULD_W-1:0] ddb1_r, ddb2_r, ddg1_r, ddg2_r;
  logic signed [tbw_pkg::MULK_W-1:0] kb1_r, kb2_r, kg1_r, kg2_r;
  logic inside2_r;
  logic signed [tbw_pkg::PXF_W-1:0] pxf, pyf;

  // Stage 3: partial sums
  logic signed [SW-1:0] sb_r, sg_r, kb_r, kg_r, sdb_r, sdg_r;
  logic inside3_r;

  // Stage 4: numerators and determinants
  logic signed [SW-1:0] nb_r, ng_r, detb_r, detg_r;
  logic inside4_r;

  // Stage 5: magnitudes
  logic [SW-1:0] unb, ung, udb, udg;

  always_comb begin
    pxf = $signed({1'b0, px_r, {tbw_pkg::VERT_FRAC_BITS{1'b0}}});
    pyf = $signed({1'b0, py_r, {tbw_pkg::VERT_FRAC_BITS{1'b0}}});
    unb = nb_r[SW-1]   ? (~$unsigned(nb_r) + 1'b1)   : $unsigned(nb_r);
    ung = ng_r[SW-1]   ? (~$unsigned(ng_r) + 1'b1)   : $unsigned(ng_r);
    udb = detb_r[SW-1] ? (~$unsigned(detb_r) + 1'b1) : $unsigned(detb_r);
    udg = detg_r[SW-1] ? (~$unsigned(detg_r) + 1'b1) : $unsigned(detg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    px_r  <= in_px;
    py_r  <= in_py;
    db1_r <= {vtx.ay[tbw_pkg::VERT_W-1], vtx.ay} - {vtx.cy[tbw_pkg::VERT_W-1], vtx.cy};
    db2_r <= {vtx.cx[tbw_pkg::VERT_W-1], vtx.cx} - {vtx.ax[tbw_pkg::VERT_W-1], vtx.ax};
    dg1_r <= {vtx.ay[tbw_pkg::VERT_W-1], vtx.ay} - {vtx.by[tbw_pkg::VERT_W-1], vtx.by};
    dg2_r <= {vtx.bx[tbw_pkg::VERT_W-1], vtx.bx} - {vtx.ax[tbw_pkg::VERT_W-1], vtx.ax};

    pb1_r  <= db1_r * pxf;
    pb2_r  <= db2_r * pyf;
    pg1_r  <= dg1_r * pxf;
    pg2_r  <= dg2_r * pyf;
    ddb1_r <= db1_r * vtx.bx;
    ddb2_r <= db2_r * vtx.by;
    ddg1_r <= dg1_r * vtx.cx;
    ddg2_r <= dg2_r * vtx.cy;
    kb1_r  <= vtx.ax * vtx.cy;
    kb2_r  <= vtx.cx * vtx.ay;
    kg1_r  <= vtx.ax * vtx.by;
    kg2_r  <= vtx.bx * vtx.ay;
    inside2_r <= (px_r >= box.min_x) && (px_r <= box.max_x) &&
                 (py_r >= box.min_y) && (py_r <= box.max_y);

    sb_r  <= SW'(pb1_r) + SW'(pb2_r);
    sg_r  <= SW'(pg1_r) + SW'(pg2_r);
    sdb_r <= SW'(ddb1_r) + SW'(ddb2_r);
    sdg_r <= SW'(ddg1_r) + SW'(ddg2_r);
    kb_r  <= SW'(kb1_r) - SW'(kb2_r);
    kg_r  <= SW'(kg1_r) - SW'(kg2_r);
    inside3_r <= inside2_r;

    nb_r   <= sb_r + kb_r;
    ng_r   <= sg_r + kg_r;
    detb_r <= sdb_r + kb_r;
    detg_r <= sdg_r + kg_r;
    inside4_r <= inside3_r;

    // Round to nearest: q = (2*|n|*2^WF + |d|) / (2*|d|)
    num_b <= tbw_pkg::NUM_W'({unb, {WF{1'b0}}, 1'b0}) + tbw_pkg::NUM_W'(udb);
    num_g <= tbw_pkg::NUM_W'({ung, {WF{1'b0}}, 1'b0}) + tbw_pkg::NUM_W'(udg);
    den_b <= {udb, 1'b0};
    den_g <= {udg, 1'b0};
    side.deg    <= (detb_r == '0) || (detg_r == '0);
    side.neg_b  <= nb_r[SW-1] ^ detb_r[SW-1];
    side.neg_g  <= ng_r[SW-1] ^ detg_r[SW-1];
    side.in_box <= inside4_r;
  end

  assign out_valid = vld_r[4];

endmodule
`default_nettype wire

>>> rtl/tbw_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module tbw_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [tbw_pkg::NUM_W-1:0] num,
  input  wire logic [tbw_pkg::DEN_W-1:0] den,
  output logic                           out_valid,
  output logic [tbw_pkg::Q_W-1:0]        quo
);

  localparam int NW = tbw_pkg::NUM_W;
  localparam int DW = tbw_pkg::DEN_W;

  logic [NW-1:0] vld_r;
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [DW-1:0] den_r [NW];
  logic [NW-1:0] quo_r [NW];

  logic [DW-1:0] rem_nxt [NW];
  logic [NW-1:0] num_nxt [NW];
  logic [DW-1:0] den_nxt [NW];
  logic [NW-1:0] quo_nxt [NW];

  logic [DW-1:0] rem_in [NW];
  logic [NW-1:0] num_in [NW];
  logic [DW-1:0] den_in [NW];
  logic [NW-1:0] quo_in [NW];
  logic [DW:0]   trial  [NW];

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      if (i == 0) begin
        rem_in[i] = '0;
        num_in[i] = num;
        den_in[i] = den;
        quo_in[i] = '0;
      end else begin
        rem_in[i] = rem_r[i-1];
        num_in[i] = num_r[i-1];
        den_in[i] = den_r[i-1];
        quo_in[i] = quo_r[i-1];
      end
      trial[i]   = {rem_in[i], num_in[i][NW-1]};
      den_nxt[i] = den_in[i];
      num_nxt[i] = {num_in[i][NW-2:0], 1'b0};
      if (trial[i] >= {1'b0, den_in[i]}) begin
        rem_nxt[i] = DW'(trial[i] - {1'b0, den_in[i]});
        quo_nxt[i] = {quo_in[i][NW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[i][DW-1:0];
        quo_nxt[i] = {quo_in[i][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NW; i++) begin
      rem_r[i] <= rem_nxt[i];
      num_r[i] <= num_nxt[i];
      den_r[i] <= den_nxt[i];
      quo_r[i] <= quo_nxt[i];
    end
  end

  assign out_valid = vld_r[NW-1];
  assign quo       = quo_r[NW-1];

endmodule
`default_nettype wire

>>> rtl/triangle_barycentric_weights_top.sv
// Top level: barycentric weights of a pixel against a configured triangle.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------------
//  input   | in_pixel_x, in_pixel_y                  | beat taken when start & !busy
//  result  | out_weight_*, out_degenerate, out_box_* | one-cycle strobe out_valid
//  config  | cfg_we, cfg_idx, cfg_wdata              | write when cfg_we is high
//
// One pixel enters every clock; busy is always low. The result strobe follows the
// accepting edge through the plane stages, the bit-per-stage divider that forms beta
// and gamma, and the sign and saturate post stages.
// Reset clears the vertex registers and every valid bit; payload flops are not reset.
// The result side cannot stall, so nothing in the pipeline ever holds.
`default_nettype none
module triangle_barycentric_weights_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [tbw_pkg::PIX_W-1:0]            in_pixel_x,
  input  wire logic [tbw_pkg::PIX_W-1:0]            in_pixel_y,
  input  wire logic                                 cfg_we,
  input  wire logic [tbw_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  wire logic [tbw_pkg::VERT_W-1:0]           cfg_wdata,
  output logic                                      out_valid,
  output logic signed [tbw_pkg::WEIGHT_W-1:0]       out_weight_alpha,
  output logic signed [tbw_pkg::WEIGHT_W-1:0]       out_weight_beta,
  output logic signed [tbw_pkg::WEIGHT_W-1:0]       out_weight_gamma,
  output logic                                      out_degenerate,
  output logic                                      out_inside_box,
  output logic [tbw_pkg::BOX_W-1:0]                 out_box_min_x,
  output logic [tbw_pkg::BOX_W-1:0]                 out_box_max_x,
  output logic [tbw_pkg::BOX_W-1:0]                 out_box_min_y,
  output logic [tbw_pkg::BOX_W-1:0]                 out_box_max_y
);

  localparam int NW = tbw_pkg::NUM_W;
  localparam int QW = tbw_pkg::Q_W;
  localparam int AW = tbw_pkg::ALPHA_W;
  localparam logic signed [AW-1:0] W_ONE = AW'(1) <<< tbw_pkg::WEIGHT_FRAC_BITS;

  // Vertex registers; the user must write them only while no pixel is in
  // flight (the block does not enforce it), so every stage may read them directly.
  tbw_pkg::vtx_t vtx_r;
  tbw_pkg::box_t box_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_r <= '0;
    end else if (cfg_we) begin
      case (tbw_pkg::cfg_reg_t'(cfg_idx))
        tbw_pkg::REG_AX: vtx_r.ax <= cfg_wdata;
        tbw_pkg::REG_AY: vtx_r.ay <= cfg_wdata;
        tbw_pkg::REG_BX: vtx_r.bx <= cfg_wdata;
        tbw_pkg::REG_BY: vtx_r.by <= cfg_wdata;
        tbw_pkg::REG_CX: vtx_r.cx <= cfg_wdata;
        tbw_pkg::REG_CY: vtx_r.cy <= cfg_wdata;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign busy = 1'b0;

  tbw_box u_box (
    .clk   (clk),
    .vtx   (vtx_r),
    .box_r (box_r)
  );

  logic                  pl_valid;
  logic [NW-1:0]         num_b, num_g;
  logic [tbw_pkg::DEN_W-1:0] den_b, den_g;
  tbw_pkg::side_t        pl_side;

  tbw_plane u_plane (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_px     (in_pixel_x),
    .in_py     (in_pixel_y),
    .vtx       (vtx_r),
    .box       (box_r),
    .out_valid (pl_valid),
    .num_b     (num_b),
    .den_b     (den_b),
    .num_g     (num_g),
    .den_g     (den_g),
    .side      (pl_side)
  );

  logic          dv_valid, dv_valid_g;
  logic [QW-1:0] q_b, q_g;

  tbw_div u_div_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pl_valid),
    .num       (num_b),
    .den       (den_b),
    .out_valid (dv_valid),
    .quo       (q_b)
  );

  tbw_div u_div_g (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pl_valid),
    .num       (num_g),
    .den       (den_g),
    .out_valid (dv_valid_g),
    .quo       (q_g)
  );

  // Delay line for the per-pixel flags, matched to the divider depth.
  tbw_pkg::side_t side_r [NW];

  always_ff @(posedge clk) begin
    side_r[0] <= pl_side;
    for (int i = 1; i < NW; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // Post stage 1: apply signs to the quotients.
  logic                 p1_valid_r;
  logic signed [QW:0]   sb_r, sg_r;
  tbw_pkg::side_t       p1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= dv_valid & dv_valid_g;
    end
  end

  always_ff @(posedge clk) begin
    sb_r      <= side_r[NW-1].neg_b ? -$signed({1'b0, q_b}) : $signed({1'b0, q_b});
    sg_r      <= side_r[NW-1].neg_g ? -$signed({1'b0, q_g}) : $signed({1'b0, q_g});
    p1_side_r <= side_r[NW-1];
  end

  // Post stage 2: alpha from the rounded values, then saturate or zero.
  logic signed [AW-1:0] beta_e, gamma_e, alpha_e;
  logic                 out_valid_r;

  always_comb begin
    beta_e  = AW'(sb_r);
    gamma_e = AW'(sg_r);
    alpha_e = W_ONE - beta_e - gamma_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_side_r.deg) begin
      out_weight_alpha <= '0;
      out_weight_beta  <= '0;
      out_weight_gamma <= '0;
    end else begin
      out_weight_alpha <= tbw_pkg::sat_w(alpha_e);
      out_weight_beta  <= tbw_pkg::sat_w(beta_e);
      out_weight_gamma <= tbw_pkg::sat_w(gamma_e);
    end
    out_degenerate <= p1_side_r.deg;
    out_inside_box <= p1_side_r.in_box;
  end

  assign out_valid     = out_valid_r;
  // Box depends only on the vertices; user, not block, holds them while pixels fly.
  assign out_box_min_x = box_r.min_x;
  assign out_box_max_x = box_r.max_x;
  assign out_box_min_y = box_r.min_y;
  assign out_box_max_y = box_r.max_y;

endmodule
`default_nettype wire

>>> verif/triangle_barycentric_weights_checker.sv
// Checker: tracks the vertex registers, predicts each pixel's weights and box, compares results.
`default_nettype none
module triangle_barycentric_weights_checker
  import tbw_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic [PIX_W-1:0]           in_pixel_x,
  input  wire logic [PIX_W-1:0]           in_pixel_y,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [VERT_W-1:0]          cfg_wdata,
  input  wire logic                       out_valid,
  input  wire logic signed [WEIGHT_W-1:0] out_weight_alpha,
  input  wire logic signed [WEIGHT_W-1:0] out_weight_beta,
  input  wire logic signed [WEIGHT_W-1:0] out_weight_gamma,
  input  wire logic                       out_degenerate,
  input  wire logic                       out_inside_box,
  input  wire logic [BOX_W-1:0]           out_box_min_x,
  input  wire logic [BOX_W-1:0]           out_box_max_x,
  input  wire logic [BOX_W-1:0]           out_box_min_y,
  input  wire logic [BOX_W-1:0]           out_box_max_y,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] alpha;
    logic signed [WEIGHT_W-1:0] beta;
    logic signed [WEIGHT_W-1:0] gamma;
    logic                       deg;
    logic                       in_box;
    logic [BOX_W-1:0]           min_x;
    logic [BOX_W-1:0]           max_x;
    logic [BOX_W-1:0]           min_y;
    logic [BOX_W-1:0]           max_y;
  } weights_t;

  logic signed [VERT_W-1:0] tri_v [6];
  weights_t weights_q [$];

  function automatic longint round_div(longint num, longint den);
    longint un, ud, q;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    un = un <<< WEIGHT_FRAC_BITS;
    q = (2 * un + ud) / (2 * ud);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] clip_weight(longint v);
    if (v < -131072) v = -131072;
    if (v > 131071) v = 131071;
    return v[WEIGHT_W-1:0];
  endfunction

  function automatic logic [BOX_W-1:0] clip_screen(longint v);
    if (v < 0) v = 0;
    if (v > SCREEN_MAX) v = SCREEN_MAX;
    return v[BOX_W-1:0];
  endfunction

  function automatic longint lo3(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint hi3(longint a, longint b, longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic weights_t pixel_weights(logic [PIX_W-1:0] pxi, logic [PIX_W-1:0] pyi);
    longint ax, ay, bx, by, cx, cy, px, py, det_b, det_g, nb, ng, beta, gamma, one;
    weights_t r;
    ax = tri_v[REG_AX]; ay = tri_v[REG_AY];
    bx = tri_v[REG_BX]; by = tri_v[REG_BY];
    cx = tri_v[REG_CX]; cy = tri_v[REG_CY];
    px = longint'(pxi) <<< VERT_FRAC_BITS;
    py = longint'(pyi) <<< VERT_FRAC_BITS;
    det_b = (ay - cy) * bx + (cx - ax) * by + ax * cy - cx * ay;
    det_g = (ay - by) * cx + (bx - ax) * cy + ax * by - bx * ay;
    one = longint'(1) <<< WEIGHT_FRAC_BITS;
    if (det_b == 0 || det_g == 0) begin
      r.alpha = '0; r.beta = '0; r.gamma = '0; r.deg = 1'b1;
    end else begin
      nb = (ay - cy) * px + (cx - ax) * py + (ax * cy - cx * ay);
      ng = (ay - by) * px + (bx - ax) * py + (ax * by - bx * ay);
      beta = round_div(nb, det_b);
      gamma = round_div(ng, det_g);
      r.alpha = clip_weight(one - beta - gamma);
      r.beta = clip_weight(beta);
      r.gamma = clip_weight(gamma);
      r.deg = 1'b0;
    end
    // floor and ceil in 4 fraction bits via arithmetic shift
    r.min_x = clip_screen(lo3(ax, bx, cx) >>> VERT_FRAC_BITS);
    r.max_x = clip_screen((hi3(ax, bx, cx) + 15) >>> VERT_FRAC_BITS);
    r.min_y = clip_screen(lo3(ay, by, cy) >>> VERT_FRAC_BITS);
    r.max_y = clip_screen((hi3(ay, by, cy) + 15) >>> VERT_FRAC_BITS);
    r.in_box = (pxi >= r.min_x && pxi <= r.max_x && pyi >= r.min_y && pyi <= r.max_y);
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    weights_t w;
    if (!rst_n) begin
      foreach (tri_v[i]) tri_v[i] <= '0;
    end else begin
      if (cfg_we && cfg_idx <= REG_CY) tri_v[cfg_idx] <= cfg_wdata;
      if (start && !busy) weights_q = {weights_q, pixel_weights(in_pixel_x, in_pixel_y)};
      if (out_valid) begin
        if (weights_q.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          w = weights_q.pop_front();
          if (out_weight_alpha !== w.alpha) report("alpha", out_weight_alpha, w.alpha);
          if (out_weight_beta !== w.beta) report("beta", out_weight_beta, w.beta);
          if (out_weight_gamma !== w.gamma) report("gamma", out_weight_gamma, w.gamma);
          if (out_degenerate !== w.deg) report("degenerate", out_degenerate, w.deg);
          if (out_inside_box !== w.in_box) report("inside_box", out_inside_box, w.in_box);
          if (out_box_min_x !== w.min_x) report("box_min_x", out_box_min_x, w.min_x);
          if (out_box_max_x !== w.max_x) report("box_max_x", out_box_max_x, w.max_x);
          if (out_box_min_y !== w.min_y) report("box_min_y", out_box_min_y, w.min_y);
          if (out_box_max_y !== w.max_y) report("box_max_y", out_box_max_y, w.max_y);
        end
      end
    end
    pending <= weights_q.size();
  end
endmodule
`default_nettype wire

>>> verif/triangle_barycentric_weights_top_tb.sv
// Testbench top: drives triangles and pixels into the block, gives the verdict.
`default_nettype none
module triangle_barycentric_weights_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;   // a margin over the pipeline depth
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [PIX_W-1:0] in_pixel_x = '0;
  logic [PIX_W-1:0] in_pixel_y = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [VERT_W-1:0] cfg_wdata = '0;

  wire logic busy, out_valid, out_degenerate, out_inside_box;
  wire logic signed [WEIGHT_W-1:0] out_weight_alpha, out_weight_beta, out_weight_gamma;
  wire logic [BOX_W-1:0] out_box_min_x, out_box_max_x, out_box_min_y, out_box_max_y;

  int errors, pending;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  triangle_barycentric_weights_top u_top (.*);

  triangle_barycentric_weights_checker u_checker (.*);

  // Hard stop in case the result stream stalls forever.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_barycentric_weights_top verification failed");
      $finish;
    end
  end

  // Load all six vertex registers back to back, plus a write to an unused index
  // that must be dropped. cfg_we stays high across the burst.
  task automatic load_triangle(logic [VERT_W-1:0] ax, logic [VERT_W-1:0] ay,
                               logic [VERT_W-1:0] bx, logic [VERT_W-1:0] by,
                               logic [VERT_W-1:0] cx, logic [VERT_W-1:0] cy);
    logic [VERT_W-1:0] vals [6];
    vals = '{ax, ay, bx, by, cx, cy};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_idx <= ($urandom_range(1)) ? REG_SPARE : REG_SPARE - 3'd1;
    cfg_wdata <= VERT_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one pixel beat after an optional gap; return at the accepting edge.
  // start is left high so a back-to-back beat needs no second assignment.
  task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, int gap);
    logic was_busy;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    // busy only moves at rising edges, so its value at the falling edge
    // is the one the next rising edge sees
    forever begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
    end
  endtask

  // Drop start and hold until every expected beat has come back.
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [VERT_W-1:0] rand_vertex();
    // mostly near the screen (-100..8300 in 1/16 pixel, about -6..519 pixels), sometimes anywhere in range
    if ($urandom_range(9) < 7) return VERT_W'($urandom_range(8400) - 100);
    return VERT_W'($urandom);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(9) < 8) return PIX_W'($urandom_range(560));
    return PIX_W'($urandom);
  endfunction

  initial begin
    int gap;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset triangle: every vertex at the origin, so degenerate.
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd1023, 10'd1023, 0);
    drain();

    // Plain triangle on screen, probing corners, edges and far pixels.
    load_triangle(16'd160, 16'd160, 16'd4000, 16'd320, 16'd800, 16'd6000);
    send_pixel(10'd10, 10'd10, 0);
    send_pixel(10'd250, 10'd10, 0);
    send_pixel(10'd50, 10'd375, 1);
    send_pixel(10'd100, 10'd100, 0);
    send_pixel(10'd0, 10'd1023, 0);
    send_pixel(10'd1023, 10'd0, 2);
    drain();

    // Vertex extremes: box clamps at both ends.
    load_triangle(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd512, 10'd512, 0);
    drain();

    // Tiny triangle far from the pixels: weights overflow the output range.
    load_triangle(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd0, 10'd0, 0);
    drain();

    // Collinear vertices: degenerate, box still reported.
    load_triangle(16'd16, 16'd16, 16'd320, 16'd320, 16'd640, 16'd640);
    send_pixel(10'd20, 10'd20, 0);
    send_pixel(10'd1, 10'd1, 0);
    drain();

    // Box entirely off screen to the left and above: min and max both clamp to zero.
    load_triangle(-16'sd800, -16'sd800, -16'sd40, -16'sd900, -16'sd600, -16'sd20);
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd1000, 10'd3, 0);
    drain();

    // Random phases: a fresh triangle each, with random pacing.
    for (int phase = 0; phase < 10; phase++) begin
      if (phase % 4 == 3) begin
        // collinear on purpose
        gap = $urandom_range(400);
        load_triangle(16'(gap), 16'(gap), 16'(gap * 2), 16'(gap * 2),
                      16'(gap * 3), 16'(gap * 3));
      end else begin
        load_triangle(rand_vertex(), rand_vertex(), rand_vertex(),
                      rand_vertex(), rand_vertex(), rand_vertex());
      end
      for (int i = 0; i < 50; i++) begin
        // some stretches run back to back, others draw a gap each beat
        gap = (phase % 3 == 0) ? 0 : $urandom_range(13);
        if (phase == 4 && i == 25) drain();
        send_pixel(rand_pixel(), rand_pixel(), gap);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("triangle_barycentric_weights_top verification clean");
    end else begin
      $display("triangle_barycentric_weights_top verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
